FILE: rtl/vpv_pkg.sv
`default_nettype none
package vpv_pkg;

   localparam int COORD_W = 32;
   localparam int ENTRY_W = 16;
   localparam int PROD_W  = COORD_W + ENTRY_W;
   localparam int CLIP_W  = 50;
   localparam int DEN_W   = CLIP_W + 1;
   localparam int REM_W   = DEN_W;
   localparam int QUO_W   = 33;
   localparam int DIV_STAGES = QUO_W;
   localparam int PIX_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT = 3'd5;

   localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_0800;
   localparam logic [63:0] ROW1_RESET = 64'h0000_0000_0800_0000;
   localparam logic [63:0] ROW2_RESET = 64'h0000_0800_0000_0000;
   localparam logic [63:0] ROW3_RESET = 64'h0800_0000_0000_0000;

   typedef logic [63:0] row_type;

   typedef struct packed {
      logic             valid;
      logic             reject;
      logic [DEN_W-1:0] den;
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
   } div_type;

endpackage
`default_nettype wire

FILE: rtl/vpv_transform.sv
`default_nettype none
module vpv_transform (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            in_valid,
   input  wire  signed [31:0]             point_x,
   input  wire  signed [31:0]             point_y,
   input  wire  signed [31:0]             point_z,
   input  wire  vpv_pkg::row_type         matrix [4],
   output vpv_pkg::div_type               div_out
);
   import vpv_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff [4][3];
   logic signed [PROD_W-1:0]  prod_in [4][3];
   logic signed [COORD_W-1:0] bias_ff [4];
   logic signed [COORD_W-1:0] bias_in [4];
   logic                      v1_ff;
   logic signed [CLIP_W-1:0]  clip_ff [4];
   logic signed [CLIP_W-1:0]  clip_in [4];
   logic                      v2_ff;
   div_type                   out_ff;
   div_type                   out_in;
   logic signed [COORD_W-1:0] pt [3];
   logic signed [DEN_W-1:0]   wx;
   logic signed [DEN_W-1:0]   cx;
   logic signed [DEN_W-1:0]   cy;
   logic signed [DEN_W-1:0]   cz;
   logic signed [DEN_W-1:0]   nx;
   logic signed [DEN_W-1:0]   ny;

   always_comb begin
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = $signed(matrix[r][16*k +: ENTRY_W]) * pt[k];
         end
         bias_in[r] = $signed({matrix[r][48 +: ENTRY_W], 16'h0000});
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         clip_in[r] = {{(CLIP_W-PROD_W){prod_ff[r][0][PROD_W-1]}}, prod_ff[r][0]}
                    + {{(CLIP_W-PROD_W){prod_ff[r][1][PROD_W-1]}}, prod_ff[r][1]}
                    + {{(CLIP_W-PROD_W){prod_ff[r][2][PROD_W-1]}}, prod_ff[r][2]}
                    + {{(CLIP_W-COORD_W){bias_ff[r][COORD_W-1]}}, bias_ff[r]};
      end
   end

   always_comb begin
      wx = {clip_ff[3][CLIP_W-1], clip_ff[3]};
      cx = {clip_ff[0][CLIP_W-1], clip_ff[0]};
      cy = {clip_ff[1][CLIP_W-1], clip_ff[1]};
      cz = {clip_ff[2][CLIP_W-1], clip_ff[2]};
      nx = cx + wx;
      ny = wx - cy;
      out_in.valid  = v2_ff;
      out_in.reject = (wx <= 0) || (cx < -wx) || (cx > wx) || (cy < -wx) || (cy > wx)
                    || (cz < -wx) || (cz > wx);
      out_in.den    = {clip_ff[3], 1'b0};
      out_in.rem_x  = nx;
      out_in.rem_y  = ny;
      out_in.quo_x  = '0;
      out_in.quo_y  = '0;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      bias_ff <= bias_in;
      clip_ff <= clip_in;
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         out_ff <= '0;
      end else begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         out_ff <= out_in;
      end
   end

   assign div_out = out_ff;

endmodule
`default_nettype wire

FILE: rtl/vpv_div_stage.sv
`default_nettype none
module vpv_div_stage #(
   parameter bit FIRST = 1'b0
) (
   input  wire              clock,
   input  wire              reset,
   input  vpv_pkg::div_type stage_in,
   output vpv_pkg::div_type stage_out
);
   import vpv_pkg::*;

   div_type          out_ff;
   div_type          out_in;
   logic [REM_W:0]   rx;
   logic [REM_W:0]   ry;
   logic [REM_W:0]   dd;
   logic             gx;
   logic             gy;
   logic [REM_W:0]   sx;
   logic [REM_W:0]   sy;

   always_comb begin
      dd = {1'b0, stage_in.den};
      rx = FIRST ? {1'b0, stage_in.rem_x} : {stage_in.rem_x, 1'b0};
      ry = FIRST ? {1'b0, stage_in.rem_y} : {stage_in.rem_y, 1'b0};
      gx = rx >= dd;
      gy = ry >= dd;
      sx = gx ? rx - dd : rx;
      sy = gy ? ry - dd : ry;
      out_in        = stage_in;
      out_in.rem_x  = sx[REM_W-1:0];
      out_in.rem_y  = sy[REM_W-1:0];
      out_in.quo_x  = {stage_in.quo_x[QUO_W-2:0], gx};
      out_in.quo_y  = {stage_in.quo_y[QUO_W-2:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign stage_out = out_ff;

endmodule
`default_nettype wire

FILE: rtl/vpv_map.sv
`default_nettype none
module vpv_map (
   input  wire                        clock,
   input  wire                        reset,
   input  vpv_pkg::div_type           map_in,
   input  wire  [31:0]                origin,
   input  wire  [31:0]                extent,
   output logic                       out_valid,
   output logic [vpv_pkg::PIX_W-1:0]  out_x,
   output logic [vpv_pkg::PIX_W-1:0]  out_y,
   output logic                       out_on
);
   import vpv_pkg::*;

   localparam int MUL_W = QUO_W + PIX_W;

   logic [MUL_W-1:0] mx_ff;
   logic [MUL_W-1:0] my_ff;
   logic             v_ff;
   logic             rej_ff;
   logic [MUL_W:0]   rx;
   logic [MUL_W:0]   ry;
   logic [17:0]      sx;
   logic [17:0]      sy;
   logic [17:0]      lx;
   logic [17:0]      ly;
   logic             vis;
   logic             valid_ff;
   logic [PIX_W-1:0] x_ff;
   logic [PIX_W-1:0] y_ff;
   logic             on_ff;

   always_comb begin
      rx  = {1'b0, mx_ff} + (MUL_W+1)'(64'h8000_0000);
      ry  = {1'b0, my_ff} + (MUL_W+1)'(64'h8000_0000);
      sx  = {2'b00, origin[15:0]} + rx[MUL_W:32];
      sy  = {2'b00, origin[31:16]} + ry[MUL_W:32];
      lx  = {2'b00, origin[15:0]} + {2'b00, extent[15:0]};
      ly  = {2'b00, origin[31:16]} + {2'b00, extent[31:16]};
      vis = !rej_ff && (sx <= lx) && (sy <= ly) && (sx[17:16] == 2'b00)
          && (sy[17:16] == 2'b00);
   end

   always_ff @(posedge clock) begin
      mx_ff  <= map_in.quo_x * extent[15:0];
      my_ff  <= map_in.quo_y * extent[31:16];
      rej_ff <= map_in.reject;
      x_ff   <= vis ? sx[PIX_W-1:0] : '0;
      y_ff   <= vis ? sy[PIX_W-1:0] : '0;
      on_ff  <= vis;
      if (reset) begin
         v_ff     <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         v_ff     <= map_in.valid;
         valid_ff <= v_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_on    = on_ff;

endmodule
`default_nettype wire

FILE: rtl/vertex_project_to_viewport.sv
// One transaction is accepted every cycle; busy is never raised.
// The 33-stage restoring divider sets the depth of the pipeline.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears the pipeline valid bits, loads an identity matrix and a zero viewport origin and extent.
`default_nettype none
module vertex_project_to_viewport (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  signed [31:0]                  req_point_x,
   input  wire  signed [31:0]                  req_point_y,
   input  wire  signed [31:0]                  req_point_z,
   output logic                                rsp_valid,
   output logic [15:0]                         rsp_screen_x,
   output logic [15:0]                         rsp_screen_y,
   output logic                                rsp_on_screen,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [vpv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [vpv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import vpv_pkg::*;

   row_type     matrix_ff [4];
   logic [31:0] origin_ff;
   logic [31:0] extent_ff;
   div_type     chain [DIV_STAGES+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[0] <= ROW0_RESET;
         matrix_ff[1] <= ROW1_RESET;
         matrix_ff[2] <= ROW2_RESET;
         matrix_ff[3] <= ROW3_RESET;
         origin_ff    <= '0;
         extent_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW0:   matrix_ff[0] <= csr_wdata;
            CSR_ROW1:   matrix_ff[1] <= csr_wdata;
            CSR_ROW2:   matrix_ff[2] <= csr_wdata;
            CSR_ROW3:   matrix_ff[3] <= csr_wdata;
            CSR_ORIGIN: origin_ff    <= csr_wdata[31:0];
            CSR_EXTENT: extent_ff    <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   vpv_transform u_transform (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .point_z  (req_point_z),
      .matrix   (matrix_ff),
      .div_out  (chain[0])
   );

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      vpv_div_stage #(
         .FIRST (i == 0)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   vpv_map u_map (
      .clock     (clock),
      .reset     (reset),
      .map_in    (chain[DIV_STAGES]),
      .origin    (origin_ff),
      .extent    (extent_ff),
      .out_valid (rsp_valid),
      .out_x     (rsp_screen_x),
      .out_y     (rsp_screen_y),
      .out_on    (rsp_on_screen)
   );

endmodule
`default_nettype wire
